FILE: rtl/core/bfdh_pkg.sv
package bfdh_pkg;

    // Default sizing of the bit store and of the probe count
    localparam int unsigned STORE_BITS_DEF = 65536;
    localparam int unsigned MAX_PROBES_DEF = 16;

    // Field and register widths
    localparam int unsigned HASH_W       = 32;
    localparam int unsigned HASH_CNT_W   = $clog2(HASH_W);
    localparam int unsigned BIT_COUNT_W  = 17;
    localparam int unsigned NUM_HASHES_W = 5;
    localparam int unsigned CFG_DATA_W   = 17;
    localparam int unsigned CFG_INDEX_W  = 1;

    localparam logic [HASH_CNT_W-1:0] HASH_LAST = HASH_CNT_W'(HASH_W - 1);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_HASHES = 1'd1;

    // Register reset values
    localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 17'd65536;
    localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 5'd7;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RED1,
        ST_RED2,
        ST_INIT,
        ST_PROBE,
        ST_INC1,
        ST_INC2,
        ST_DONE
    } seq_state_t;

    // Bit store access controls
    typedef struct packed {
        logic wr;
        logic rd;
        logic wbit;
    } mem_ctl_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic res_load;
        logic res_found;
    } seq_status_t;

endpackage

FILE: rtl/core/bfdh_modadd.sv
module bfdh_modadd
    import bfdh_pkg::*;
#(
    parameter int unsigned STORE_BITS = STORE_BITS_DEF
)
(
    input  logic [$clog2(STORE_BITS)-1:0]   a,
    input  logic [$clog2(STORE_BITS)-1:0]   b,
    input  logic                            cin,
    input  logic [$clog2(STORE_BITS+1)-1:0] modulus,
    output logic [$clog2(STORE_BITS)-1:0]   sum
);

    localparam int unsigned IW = $clog2(STORE_BITS);
    localparam int unsigned AW = $clog2(STORE_BITS + 1);
    localparam int unsigned SW = AW + 1;

    logic [SW-1:0] raw;
    logic [SW-1:0] diff;

    // Operands are below the modulus, so one conditional subtract reduces the sum
    always_comb
    begin
        raw  = SW'(a) + SW'(b) + SW'(cin);
        diff = raw - SW'(modulus);
        if (raw >= SW'(modulus))
        begin
            sum = diff[IW-1:0];
        end
        else
        begin
            sum = raw[IW-1:0];
        end
    end

endmodule

FILE: rtl/core/bfdh_bitmem.sv
module bfdh_bitmem
    import bfdh_pkg::*;
#(
    parameter int unsigned STORE_BITS = STORE_BITS_DEF
)
(
    input  logic                          clk,
    input  mem_ctl_t                      ctl,
    input  logic [$clog2(STORE_BITS)-1:0] addr,
    output logic                          rd_bit
);

    logic mem [STORE_BITS];
    logic rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= ctl.wbit;
        end
        if (ctl.rd)
        begin
            rd_reg <= mem[addr];
        end
    end

    assign rd_bit = rd_reg;

endmodule

FILE: rtl/core/bfdh_ctrl.sv
module bfdh_ctrl
    import bfdh_pkg::*;
#(
    parameter int unsigned STORE_BITS = STORE_BITS_DEF,
    parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          operation,
    input  logic [HASH_W-1:0]             hash_first,
    input  logic [HASH_W-1:0]             hash_second,
    input  logic [BIT_COUNT_W-1:0]        bit_count,
    input  logic [NUM_HASHES_W-1:0]       num_hashes,
    input  logic                          res_ready,
    input  logic                          rd_bit,
    output mem_ctl_t                      mem_ctl,
    output logic [$clog2(STORE_BITS)-1:0] mem_addr,
    output seq_status_t                   status
);

    localparam int unsigned IW = $clog2(STORE_BITS);
    localparam int unsigned AW = $clog2(STORE_BITS + 1);
    localparam int unsigned PW = $clog2(MAX_PROBES + 1);

    seq_state_t              state_reg, state_next;
    logic [IW-1:0]           x_reg, x_next;
    logic [IW-1:0]           d_reg, d_next;
    logic [AW-1:0]           m_reg, m_next;
    logic [PW-1:0]           n_reg, n_next;
    logic [PW-1:0]           i_reg, i_next;
    logic [HASH_CNT_W-1:0]   bit_reg, bit_next;
    logic [HASH_W-1:0]       hsh_reg, hsh_next;
    logic [HASH_W-1:0]       h2_reg, h2_next;
    logic                    op_reg, op_next;
    logic                    found_reg, found_next;

    logic [IW-1:0]           ua, ub, usum;
    logic                    ucin;
    logic [31:0]             bc_wide, m_wide, nh_wide, n_wide;

    bfdh_modadd #(
        .STORE_BITS (STORE_BITS)
    ) u_modadd (
        .a       (ua),
        .b       (ub),
        .cin     (ucin),
        .modulus (m_reg),
        .sum     (usum)
    );

    // Clamp the registers to the usable modulus and probe count
    always_comb
    begin
        bc_wide = 32'(bit_count);
        nh_wide = 32'(num_hashes);
        if (bc_wide == 32'd0)
        begin
            m_wide = 32'd1;
        end
        else if (bc_wide > 32'(STORE_BITS))
        begin
            m_wide = 32'(STORE_BITS);
        end
        else
        begin
            m_wide = bc_wide;
        end
        if (nh_wide > 32'(MAX_PROBES))
        begin
            n_wide = 32'(MAX_PROBES);
        end
        else
        begin
            n_wide = nh_wide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            x_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        m_reg     <= m_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        bit_reg   <= bit_next;
        hsh_reg   <= hsh_next;
        h2_reg    <= h2_next;
        op_reg    <= op_next;
        found_reg <= found_next;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        bit_next   = bit_reg;
        hsh_next   = hsh_reg;
        h2_next    = h2_reg;
        op_next    = op_reg;
        found_next = found_reg;
        ua         = d_reg;
        ub         = '0;
        ucin       = 1'b1;
        mem_ctl    = '0;
        status     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr = 1'b1;
                if (x_reg == IW'(STORE_BITS - 1))
                begin
                    x_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    x_next = x_reg + IW'(1);
                end
            end
            ST_IDLE:
            begin
                status.idle = 1'b1;
                if (item_valid)
                begin
                    m_next     = m_wide[AW-1:0];
                    n_next     = n_wide[PW-1:0];
                    op_next    = operation;
                    hsh_next   = hash_first;
                    h2_next    = hash_second;
                    x_next     = '0;
                    i_next     = '0;
                    bit_next   = '0;
                    found_next = (operation == OP_QUERY);
                    state_next = ST_RED1;
                end
            end
            ST_RED1:
            begin
                // Restoring reduction of the first hash, one bit per cycle
                ua       = x_reg;
                ub       = x_reg;
                ucin     = hsh_reg[HASH_W-1];
                x_next   = usum;
                hsh_next = hsh_reg << 1;
                bit_next = bit_reg + HASH_CNT_W'(1);
                if (bit_reg == HASH_LAST)
                begin
                    hsh_next   = h2_reg;
                    d_next     = '0;
                    state_next = ST_RED2;
                end
            end
            ST_RED2:
            begin
                ua       = d_reg;
                ub       = d_reg;
                ucin     = hsh_reg[HASH_W-1];
                d_next   = usum;
                hsh_next = hsh_reg << 1;
                bit_next = bit_reg + HASH_CNT_W'(1);
                if (bit_reg == HASH_LAST)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                // First step between probes is second hash plus one
                d_next     = usum;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        mem_ctl.wr   = 1'b1;
                        mem_ctl.wbit = 1'b1;
                    end
                    else
                    begin
                        mem_ctl.rd = 1'b1;
                    end
                    ua         = x_reg;
                    ub         = d_reg;
                    ucin       = 1'b0;
                    x_next     = usum;
                    i_next     = i_reg + PW'(1);
                    state_next = ST_INC1;
                end
            end
            ST_INC1:
            begin
                // Step grows by two per probe: add one here and one in the next cycle
                d_next = usum;
                if ((op_reg == OP_QUERY) && !rd_bit)
                begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_INC2;
                end
            end
            ST_INC2:
            begin
                d_next     = usum;
                state_next = ST_PROBE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    status.res_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        status.res_found = found_reg;
    end

    assign mem_addr = x_reg;

endmodule

FILE: rtl/core/bloom_filter_double_hash.sv
// Bloom filter with enhanced double hashing. Each item carries an operation
// (insert or query) and two 32-bit hashes of a key; probe i of the key hits
// bit (hash_first + i*hash_second + i*i) mod bit_count of a 1-bit store.
// An insert sets every probed bit and returns found = 0; a query returns 1
// only when every probed bit is set (also when num_hashes is 0). bit_count is
// clamped to 1..STORE_BITS and num_hashes to MAX_PROBES. After reset the
// block sweeps all STORE_BITS bits of the store clear (65536 by default),
// one bit per cycle, and holds item_stall high meanwhile; config writes are
// taken at any time but are meant for idle periods only. The sequence uses
// a single modular adder that first reduces both hashes bit serially, then
// forms the first probe step, then for each probe advances the index and
// steps the probe increment twice, and finally closes the probe loop and
// loads the result. A query that meets a clear bit stops at that probe.
// The store has one port, used once per probe. The next item is accepted
// in the cycle after the result is registered, even while that result
// still waits on result_stall.
module bloom_filter_double_hash
    import bfdh_pkg::*;
#(
    parameter int unsigned STORE_BITS = STORE_BITS_DEF,
    parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // Input items
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic                    operation,
    input  logic [HASH_W-1:0]       hash_first,
    input  logic [HASH_W-1:0]       hash_second,

    // Result items
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    found,

    // Register writes
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned IW = $clog2(STORE_BITS);

    logic [BIT_COUNT_W-1:0]  bit_count_reg;
    logic [NUM_HASHES_W-1:0] num_hashes_reg;
    logic                    result_valid_reg;
    logic                    found_reg;
    logic                    res_ready;
    logic                    rd_bit;
    mem_ctl_t                mem_ctl;
    logic [IW-1:0]           mem_addr;
    seq_status_t             status;

    // Register file: writes land immediately and never touch the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= BIT_COUNT_RST;
            num_hashes_reg <= NUM_HASHES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BIT_COUNT:  bit_count_reg  <= cfg_data[BIT_COUNT_W-1:0];
                REG_NUM_HASHES: num_hashes_reg <= cfg_data[NUM_HASHES_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer with the shared modular adder
    bfdh_ctrl #(
        .STORE_BITS (STORE_BITS),
        .MAX_PROBES (MAX_PROBES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .operation   (operation),
        .hash_first  (hash_first),
        .hash_second (hash_second),
        .bit_count   (bit_count_reg),
        .num_hashes  (num_hashes_reg),
        .res_ready   (res_ready),
        .rd_bit      (rd_bit),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .status      (status)
    );

    // Single-port bit store, registered read
    bfdh_bitmem #(
        .STORE_BITS (STORE_BITS)
    ) u_bitmem (
        .clk    (clk),
        .ctl    (mem_ctl),
        .addr   (mem_addr),
        .rd_bit (rd_bit)
    );

    // Output register: free when empty or being taken this cycle
    assign res_ready = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (status.res_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Hold the payload while stalled; load only with a new result
    always_ff @(posedge clk)
    begin
        if (status.res_load)
        begin
            found_reg <= status.res_found;
        end
    end

    assign item_stall   = !status.idle;
    assign result_valid = result_valid_reg;
    assign found        = found_reg;

endmodule

FILE: rtl/core/bfdh_checker.sv
module bfdh_checker
    import bfdh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_stall,
    input  logic                    result_valid,
    input  logic                    result_stall,
    input  logic                    found
);

    logic       item_take;
    logic       result_take;
    logic [1:0] pend_reg, pend_next;

    assign item_take   = item_valid && !item_stall;
    assign result_take = result_valid && !result_stall;

    // Count items accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (item_take && !result_take)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!item_take && result_take)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(found))
        else $error("stalled result changed or dropped");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> item_stall)
        else $error("item accepted while previous one still in work");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result shown with no item outstanding");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items outstanding");

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found)
);
